/* rtl/core/lppd_pkg.sv */
`timescale 1ns / 1ps

package lppd_pkg;

    // Frame header layout: 4 magic bytes, 1 type byte, 4 length bytes
    localparam int HEADER_BYTES = 9;
    localparam int MAGIC_BYTES  = 4;
    localparam int CNT_W        = 4;
    localparam int LEN_W        = 23;

    localparam logic [CNT_W-1:0] TYPE_POS = CNT_W'(MAGIC_BYTES);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(HEADER_BYTES - 1);

    // Register map (word index)
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_MAGIC   = 3'd0;
    localparam logic [2:0] REG_MAX_LEN = 3'd1;
    localparam logic [2:0] REG_AUDIO   = 3'd2;
    localparam logic [2:0] REG_CONTROL = 3'd3;
    localparam logic [2:0] REG_VIDEO   = 3'd4;

    // Register reset values
    localparam logic [31:0]      MAGIC_RST   = 32'h5254_5353;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 23'd4194304;
    localparam logic [7:0]       AUDIO_RST   = 8'd2;
    localparam logic [7:0]       CONTROL_RST = 8'd3;
    localparam logic [7:0]       VIDEO_RST   = 8'd1;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Packet classes
    localparam logic [1:0] CLS_AUDIO   = 2'd0;
    localparam logic [1:0] CLS_CONTROL = 2'd1;
    localparam logic [1:0] CLS_VIDEO   = 2'd2;
    localparam logic [1:0] CLS_UNKNOWN = 2'd3;

    // Framing error codes
    localparam logic ERR_MAGIC  = 1'b0;
    localparam logic ERR_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [31:0]      magic_word;
        logic [LEN_W-1:0] max_payload;
        logic [7:0]       audio_code;
        logic [7:0]       control_code;
        logic [7:0]       video_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] packet_class;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       error_code;
    } result_t;

    // Audio wins over control, control over video
    function automatic logic [1:0] class_of(input logic [7:0] t, input cfg_t cfg);
        logic [1:0] cls;
        if (t == cfg.audio_code)
            cls = CLS_AUDIO;
        else if (t == cfg.control_code)
            cls = CLS_CONTROL;
        else if (t == cfg.video_code)
            cls = CLS_VIDEO;
        else
            cls = CLS_UNKNOWN;
        return cls;
    endfunction

endpackage

/* rtl/core/lppd_parser.sv */
`timescale 1ns / 1ps

module lppd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             cmd,
    input  logic [7:0]       rx_byte,
    input  lppd_pkg::cfg_t   cfg,
    output logic             res_valid,
    output lppd_pkg::result_t res
);
    import lppd_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   header_count_reg, header_count_next;
    logic [31:0]        magic_shift_reg, magic_shift_next;
    logic [7:0]         type_byte_reg, type_byte_next;
    logic [31:0]        length_shift_reg, length_shift_next;
    logic [LEN_W-1:0]   bytes_left_reg, bytes_left_next;

    logic [31:0] len_full;
    logic        is_last;

    assign len_full = {rx_byte, length_shift_reg[31:8]};
    assign is_last  = (bytes_left_reg <= LEN_W'(1));

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= '0;
            magic_shift_reg  <= '0;
            type_byte_reg    <= '0;
            length_shift_reg <= '0;
            bytes_left_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            magic_shift_reg  <= magic_shift_next;
            type_byte_reg    <= type_byte_next;
            length_shift_reg <= length_shift_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

    // Next state and result for the byte at the input
    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        magic_shift_next  = magic_shift_reg;
        type_byte_next    = type_byte_reg;
        length_shift_next = length_shift_reg;
        bytes_left_next   = bytes_left_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (cmd)
        begin
            // new connection: start over
            phase_next        = PH_HEADER;
            header_count_next = '0;
            magic_shift_next  = '0;
            type_byte_next    = '0;
            length_shift_next = '0;
            bytes_left_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (header_count_reg < TYPE_POS)
                        magic_shift_next = {rx_byte, magic_shift_reg[31:8]};
                    else if (header_count_reg == TYPE_POS)
                        type_byte_next = rx_byte;
                    else
                        length_shift_next = len_full;

                    if (header_count_reg != LAST_POS)
                        header_count_next = header_count_reg + CNT_W'(1);
                    else
                    begin
                        // full header in: check it
                        header_count_next = '0;
                        if (magic_shift_reg != cfg.magic_word)
                        begin
                            phase_next     = PH_DROP;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_MAGIC;
                        end
                        else if (len_full > {9'd0, cfg.max_payload})
                        begin
                            phase_next     = PH_DROP;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_LENGTH;
                        end
                        else if (len_full == 32'd0)
                        begin
                            res_valid        = 1'b1;
                            res.kind         = KIND_EMPTY;
                            res.packet_class = class_of(type_byte_reg, cfg);
                        end
                        else
                        begin
                            bytes_left_next = len_full[LEN_W-1:0];
                            phase_next      = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_DATA;
                    res.packet_class = class_of(type_byte_reg, cfg);
                    res.data_byte    = rx_byte;
                    res.last_byte    = is_last;
                    if (is_last)
                    begin
                        bytes_left_next   = '0;
                        phase_next        = PH_HEADER;
                        header_count_next = '0;
                    end
                    else
                        bytes_left_next = bytes_left_reg - LEN_W'(1);
                end
                default:
                begin
                    // dropping until the next connection
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg <= LAST_POS)
        else $error("header count past end of header");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> bytes_left_reg != '0)
        else $error("payload phase with no bytes left");

    a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid && res.kind == KIND_ERROR |=> phase_reg == PH_DROP)
        else $error("framing error did not enter drop phase");

    a_header_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !cmd && phase_reg == PH_HEADER && header_count_reg != LAST_POS
        |-> !res_valid)
        else $error("result on a partial header");
`endif

endmodule

/* rtl/core/lppd_out_buf.sv */
`timescale 1ns / 1ps

module lppd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lppd_pkg::result_t push_data,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output lppd_pkg::result_t out_data
);
    import lppd_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign ready     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign pop       = main_valid_reg && out_ready;

    // Output register plus one skid entry
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

/* rtl/core/length_prefixed_packet_deframer.sv */
`timescale 1ns / 1ps

// Byte stream deframer: takes one received byte (or a new-connection command)
// per cycle while in_ready is high and delivers payload bytes tagged with
// class and last flag, an empty-packet notice for zero-length frames, or a
// framing error. Each item is handled in the cycle it is accepted, so the
// block sustains one item per clock while in_ready is high; each result is
// registered in an output register with one skid entry, so input keeps
// flowing while the consumer stalls; in_ready drops only once both are full.
// Configuration registers are written over the APB port at byte address 4*i.
module length_prefixed_packet_deframer (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lppd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic [7:0]                  rx_byte,
    // output channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic [1:0]                  packet_class,
    output logic [7:0]                  data_byte,
    output logic                        last_byte,
    output logic                        error_code
);
    import lppd_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic       advance;
    logic       res_valid;
    result_t    res;
    result_t    out_data;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word   <= MAGIC_RST;
            cfg_reg.max_payload  <= MAX_LEN_RST;
            cfg_reg.audio_code   <= AUDIO_RST;
            cfg_reg.control_code <= CONTROL_RST;
            cfg_reg.video_code   <= VIDEO_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_MAGIC:   cfg_reg.magic_word   <= pwdata;
                REG_MAX_LEN: cfg_reg.max_payload  <= pwdata[LEN_W-1:0];
                REG_AUDIO:   cfg_reg.audio_code   <= pwdata[7:0];
                REG_CONTROL: cfg_reg.control_code <= pwdata[7:0];
                REG_VIDEO:   cfg_reg.video_code   <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_idx)
            REG_MAGIC:   prdata = cfg_reg.magic_word;
            REG_MAX_LEN: prdata = {9'd0, cfg_reg.max_payload};
            REG_AUDIO:   prdata = {24'd0, cfg_reg.audio_code};
            REG_CONTROL: prdata = {24'd0, cfg_reg.control_code};
            REG_VIDEO:   prdata = {24'd0, cfg_reg.video_code};
            default:     prdata = '0;
        endcase
    end

    assign advance = in_valid && in_ready;

    lppd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cmd       (cmd),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    lppd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && res_valid),
        .push_data (res),
        .ready     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind         = out_data.kind;
    assign packet_class = out_data.packet_class;
    assign data_byte    = out_data.data_byte;
    assign last_byte    = out_data.last_byte;
    assign error_code   = out_data.error_code;

endmodule
